@@ rtl/glnp_pkg.sv @@
package glnp_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int MAX_WINDOW_DEF  = 65536;

   localparam int SUM_W     = 64;
   localparam int NORM_W    = 28;
   localparam int WIN_W     = 17;
   localparam int P_W       = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_P_ORDER    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = 2'd1;

   localparam logic [P_W-1:0]   P_RESET   = 3'd2;
   localparam logic [WIN_W-1:0] WIN_RESET = 17'd1;

   localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

   // two-entry job queue between the accumulator and the root unit
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [P_W-1:0]   p;
   } job_type;

   typedef struct packed {
      logic [P_W-1:0]   p;
      logic [WIN_W-1:0] window;
   } cfg_type;

endpackage

@@ rtl/global_lp_norm_pool_unit.sv @@
// channel  ports                                      direction
// req      req_push, req_full, req_sample             samples in, queue style
// rsp      rsp_empty, rsp_pop, rsp_norm               norms out, queue style
// csr      csr_valid, csr_ready, csr_index, csr_wdata register writes
//
// Samples enter at one per cycle while req_full is low, via a three-stage
// power pipeline and a saturating accumulator; a completed window enters
// a two-entry job queue. The root unit takes it, searches the norm bit by
// bit on the shared 32x32 multiplier (a square, two more products for p = 3
// or one for p = 4, a compare; none for p = 1) and then hands it over.
// req_full rises only when a window ends while the job queue is full.
// Synchronous active-high reset clears the pipe, sums, counters and queues.
module global_lp_norm_pool_unit
   import glnp_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [NORM_W-1:0]           rsp_norm,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [WIN_W-1:0]            csr_wdata
);

   logic [P_W-1:0]   p_order_ff;
   logic [WIN_W-1:0] window_len_ff;
   cfg_type          cfg;

   logic    fr_job_valid, fr_job_ready;
   job_type fr_job;
   logic    rt_job_valid, rt_job_ready;
   job_type rt_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_order_ff    <= P_RESET;
         window_len_ff <= WIN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_P_ORDER:    p_order_ff    <= csr_wdata[P_W-1:0];
            CSR_WINDOW_LEN: window_len_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // clamp exponent to 1..4 and window to 1..MAX_WINDOW
   always_comb begin
      if (p_order_ff == '0) begin
         cfg.p = 3'd1;
      end else if (p_order_ff > 3'd4) begin
         cfg.p = 3'd4;
      end else begin
         cfg.p = p_order_ff;
      end
      if (window_len_ff == '0) begin
         cfg.window = WIN_W'(1);
      end else if (window_len_ff > WIN_W'(MAX_WINDOW)) begin
         cfg.window = WIN_W'(MAX_WINDOW);
      end else begin
         cfg.window = window_len_ff;
      end
   end

   glnp_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .push      (req_push),
      .sample    (req_sample),
      .full      (req_full),
      .job_valid (fr_job_valid),
      .job_ready (fr_job_ready),
      .job       (fr_job)
   );

   glnp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_job_valid),
      .in_ready  (fr_job_ready),
      .in_job    (fr_job),
      .out_valid (rt_job_valid),
      .out_ready (rt_job_ready),
      .out_job   (rt_job)
   );

   glnp_root u_root (
      .clock     (clock),
      .reset     (reset),
      .job_valid (rt_job_valid),
      .job_ready (rt_job_ready),
      .job       (rt_job),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .norm      (rsp_norm)
   );

endmodule

@@ rtl/glnp_front.sv @@
module glnp_front
   import glnp_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   push,
   input  logic [SAMPLE_BITS-1:0] sample,
   output logic                   full,
   output logic                   job_valid,
   input  logic                   job_ready,
   output job_type                job
);

   localparam int MAG_W  = SAMPLE_BITS;
   localparam int SQ_W   = 2 * SAMPLE_BITS;
   localparam int CUBE_W = 3 * SAMPLE_BITS;
   localparam int TERM_W = 4 * SAMPLE_BITS;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [MAG_W-1:0]  mag1_ff, mag2_ff;
   logic [SQ_W-1:0]   sq2_ff;
   logic [TERM_W-1:0] term3_ff;
   logic [P_W-1:0]    p1_ff, p2_ff, p3_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [WIN_W-1:0]  cnt_ff;

   logic [MAG_W-1:0]  mag_in;
   logic [SQ_W-1:0]   sq_in;
   logic [CUBE_W-1:0] cube;
   logic [TERM_W-1:0] quad;
   logic [TERM_W-1:0] term_in;
   logic [SUM_W:0]    sum_add;
   logic [SUM_W-1:0]  sum_sat;
   logic [WIN_W-1:0]  cnt_in;
   logic              done_now;
   logic              advance;

   assign mag_in = sample[MAG_W-1] ? (~sample + 1'b1) : sample;
   assign sq_in  = mag1_ff * mag1_ff;
   assign cube   = sq2_ff * mag2_ff;
   assign quad   = sq2_ff * sq2_ff;

   always_comb begin
      case (p2_ff)
         3'd1:    term_in = TERM_W'(mag2_ff);
         3'd2:    term_in = TERM_W'(sq2_ff);
         3'd3:    term_in = TERM_W'(cube);
         default: term_in = quad;
      endcase
   end

   // saturating accumulate
   assign sum_add  = {1'b0, sum_ff} + (SUM_W + 1)'(term3_ff);
   assign sum_sat  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
   assign cnt_in   = cnt_ff + 1'b1;
   assign done_now = cnt_in >= cfg.window;

   // hold the whole pipe while a finished window cannot enter the queue
   assign advance   = !(s3_valid_ff && done_now && !job_ready);
   assign full      = !advance;
   assign job_valid = s3_valid_ff && done_now;
   assign job.sum   = sum_sat;
   assign job.p     = p3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
      end else if (advance) begin
         s1_valid_ff <= push;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (s3_valid_ff) begin
            if (done_now) begin
               sum_ff <= '0;
               cnt_ff <= '0;
            end else begin
               sum_ff <= sum_sat;
               cnt_ff <= cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag1_ff  <= mag_in;
         p1_ff    <= cfg.p;
         mag2_ff  <= mag1_ff;
         sq2_ff   <= sq_in;
         p2_ff    <= p1_ff;
         term3_ff <= term_in;
         p3_ff    <= p2_ff;
      end
   end

endmodule

@@ rtl/glnp_queue.sv @@
module glnp_queue
   import glnp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign in_ready  = count_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_job   = entry_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

@@ rtl/glnp_root.sv @@
module glnp_root
   import glnp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  job_type           job,
   output logic              empty,
   input  logic              pop,
   output logic [NORM_W-1:0] norm
);

   localparam int MUL_W   = 32;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int HI_W    = 34;
   localparam int CMP_W   = SUM_W + 2;
   localparam int IDX_W   = $clog2(NORM_W);

   // top result bit per exponent: the root of a 64-bit sum stays below
   // 2^32, 2^22 and 2^16; squares clamp to the 28-bit norm range
   localparam logic [IDX_W-1:0] IDX_P2 = IDX_W'(NORM_W - 1);
   localparam logic [IDX_W-1:0] IDX_P3 = 5'd21;
   localparam logic [IDX_W-1:0] IDX_P4 = 5'd15;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_M2   = 3'd2;
   localparam logic [2:0] ST_M3   = 3'd3;
   localparam logic [2:0] ST_CMP  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [P_W-1:0]    p_ff, p_in;
   logic [NORM_W-1:0] res_ff, res_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [PROD_W-1:0] sq_ff, sq_in;
   logic [PROD_W-1:0] pw_ff, pw_in;
   logic [HI_W-1:0]   hi_ff, hi_in;
   logic              out_valid_ff, out_valid_in;
   logic [NORM_W-1:0] norm_ff, norm_in;

   logic [NORM_W-1:0] bit_mask, cand;
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic [CMP_W-1:0]  pw_total;
   logic              fits;

   assign bit_mask = NORM_W'(1) << idx_ff;
   assign cand     = res_ff | bit_mask;
   assign prod     = mul_a * mul_b;
   assign pw_total = CMP_W'(pw_ff) + {hi_ff, {MUL_W{1'b0}}};
   assign fits     = pw_total <= CMP_W'(sum_ff);

   assign job_ready = state_ff == ST_IDLE;
   assign empty     = !out_valid_ff;
   assign norm      = norm_ff;

   always_comb begin
      case (state_ff)
         ST_M2: begin
            mul_a = sq_ff[MUL_W-1:0];
            mul_b = (p_ff == 3'd4) ? sq_ff[MUL_W-1:0] : MUL_W'(cand);
         end
         ST_M3: begin
            mul_a = MUL_W'(sq_ff[43:32]);
            mul_b = MUL_W'(cand);
         end
         default: begin
            mul_a = MUL_W'(cand);
            mul_b = MUL_W'(cand);
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      p_in         = p_ff;
      res_in       = res_ff;
      idx_in       = idx_ff;
      sq_in        = sq_ff;
      pw_in        = pw_ff;
      hi_in        = hi_ff;
      out_valid_in = out_valid_ff && !pop;
      norm_in      = norm_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               sum_in = job.sum;
               p_in   = job.p;
               res_in = '0;
               case (job.p)
                  3'd1: begin
                     res_in   = (|job.sum[SUM_W-1:NORM_W]) ? NORM_MAX
                                                           : job.sum[NORM_W-1:0];
                     state_in = ST_DONE;
                  end
                  3'd2: begin
                     idx_in   = IDX_P2;
                     state_in = ST_SQ;
                  end
                  3'd3: begin
                     idx_in   = IDX_P3;
                     state_in = ST_SQ;
                  end
                  default: begin
                     idx_in   = IDX_P4;
                     state_in = ST_SQ;
                  end
               endcase
            end
         end
         ST_SQ: begin
            sq_in    = prod;
            pw_in    = prod;
            hi_in    = '0;
            state_in = (p_ff == 3'd2) ? ST_CMP : ST_M2;
         end
         ST_M2: begin
            pw_in    = prod;
            state_in = (p_ff == 3'd3) ? ST_M3 : ST_CMP;
         end
         ST_M3: begin
            hi_in    = prod[HI_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (fits) begin
               res_in = cand;
            end
            if (idx_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = ST_SQ;
            end
         end
         ST_DONE: begin
            // wait for the output slot to drain
            if (!out_valid_ff) begin
               norm_in      = res_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      p_ff    <= p_in;
      res_ff  <= res_in;
      idx_ff  <= idx_in;
      sq_ff   <= sq_in;
      pw_ff   <= pw_in;
      hi_ff   <= hi_in;
      norm_ff <= norm_in;
   end

endmodule
